// ===== rtl/union_find_graph_segmenter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Union-find segmenter assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_GRAPH_SEGMENTER_UNIT_ASSERT_SVH
`define UNION_FIND_GRAPH_SEGMENTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define UFGS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ufgs assertion failed");
`define UFGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error("ufgs assertion failed");
`else
`define UFGS_ASSERT(label, prop)
`define UFGS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/ufgs_pkg.sv =====
// ----------------------------------------------------------------------------
// Union-find segmenter package
// Shared constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package ufgs_pkg;
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int WEIGHT_BITS_DEF  = 16;
	localparam int SCALE_W          = 16;
	localparam int NV_W             = 11;
	localparam int CFG_W            = 16;
	localparam int RANK_W           = 4;
	localparam int EPOCH_W          = 8;
	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
	localparam logic [NV_W-1:0] NV_RESET = 11'd1024;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	localparam logic REG_NUM_VERTICES = 1'b0;
	localparam logic REG_SCALE_K      = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_CHECK,
		ST_RD,
		ST_CHK,
		ST_WR,
		ST_DECIDE,
		ST_DIV,
		ST_WR_CHILD,
		ST_WR_TOP,
		ST_DONE
	} ufgs_state_t;
endpackage

// ===== rtl/ufgs_edge_if.sv =====
// ----------------------------------------------------------------------------
// Edge channel
// Valid/ready channel carrying one graph edge per transfer.
// ----------------------------------------------------------------------------
interface ufgs_edge_if #(
	parameter int VW = 10,
	parameter int WB = 16
);
	logic          valid;
	logic          ready;
	logic [VW-1:0] node_a;
	logic [VW-1:0] node_b;
	logic [WB-1:0] edge_weight;
	logic          first_edge;

	modport source (output valid, node_a, node_b, edge_weight, first_edge, input ready);
	modport sink (input valid, node_a, node_b, edge_weight, first_edge, output ready);
endinterface

// ===== rtl/ufgs_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result per processed edge.
// ----------------------------------------------------------------------------
interface ufgs_result_if #(
	parameter int VW = 10,
	parameter int CW = 11
);
	logic          valid;
	logic          ready;
	logic          merged;
	logic [VW-1:0] result_root;
	logic [CW-1:0] set_count;
	logic [CW-1:0] root_size;
	logic          index_error;

	modport source (output valid, merged, result_root, set_count, root_size, index_error,
		input ready);
	modport sink (input valid, merged, result_root, set_count, root_size, index_error,
		output ready);
endinterface

// ===== rtl/ufgs_divider.sv =====
// ----------------------------------------------------------------------------
// Union-find segmenter divider
// Restoring divider, one quotient bit per cycle; quotient holds after done.
// ----------------------------------------------------------------------------
module ufgs_divider
	import ufgs_pkg::*;
#(
	parameter int DEN_W = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SCALE_W-1:0] dividend,
	input  logic [DEN_W-1:0]   divisor,
	output logic               done,
	output logic [SCALE_W-1:0] quotient
);
	localparam int CNT_W = $clog2(SCALE_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] div_q;
	logic [SCALE_W-1:0] quo_q;
	logic [DEN_W:0]   shifted;
	logic             ge;

	always_comb begin
		shifted = {rem_q, quo_q[SCALE_W-1]};
		ge      = shifted >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SCALE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(shifted - {1'b0, div_q}) : shifted[DEN_W-1:0];
			quo_q <= {quo_q[SCALE_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/union_find_graph_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// Union-find graph segmenter
// Threshold-based segmentation engine: find, compress and union by rank.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                           | handshake
//  edges    | in  | node_a, node_b, edge_weight, first_edge           | valid/ready
//  results  | out | merged, result_root, set_count, root_size, index_error | valid/ready
//  cfg      | in  | cfg_index, cfg_data                               | cfg_write
//
// One edge at a time. Each find reads one vertex per node that it visits,
// plus one write per compressed endpoint; a merge adds a divider run
// (16 quotient steps) and two vertex-memory writes.
// After reset, and whenever first_edge wraps the epoch counter, a clearing
// pass sweeps every vertex-memory entry; no edge is taken then.
// A stalled result waits in the output register while the next edge runs.
`include "union_find_graph_segmenter_unit_assert.svh"

module union_find_graph_segmenter_unit
	import ufgs_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	ufgs_edge_if.sink          edges,
	ufgs_result_if.source      results
);
	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int THR_W = (WEIGHT_BITS + 1 > SCALE_W) ? WEIGHT_BITS + 1 : SCALE_W;
	localparam int SUM_W = ((WEIGHT_BITS > SCALE_W) ? WEIGHT_BITS : SCALE_W) + 1;
	localparam int NC_W  = (NV_W > CW) ? NV_W : CW;
	localparam logic [SUM_W-1:0] THR_SAT = (SUM_W'(1) << (WEIGHT_BITS + 1)) - 1'b1;
	localparam logic [CW-1:0] SETS_RESET =
		(MAX_VERTICES < 1024) ? CW'(MAX_VERTICES) : CW'(1024);

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [VW-1:0]      parent;
		logic [RANK_W-1:0]  rank;
		logic [CW-1:0]      size;
		logic [THR_W-1:0]   thr;
	} entry_t;

	ufgs_state_t state_q, state_d;

	// configuration
	logic [NV_W-1:0]    num_vertices_q;
	logic [SCALE_W-1:0] scale_k_q;

	// vertex memory
	entry_t mem [MAX_VERTICES];
	entry_t rdata_q;
	logic   mem_we;
	logic [VW-1:0] mem_waddr;
	entry_t mem_wdata;

	// control and datapath
	logic [EPOCH_W-1:0] epoch_q;
	logic [CW-1:0]      sets_left_q;
	logic [VW-1:0]      clr_idx_q;
	logic               resume_q;
	logic [VW-1:0]      na_q, nb_q, cur_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic               first_q;
	logic [CW-1:0]      steps_q;
	logic               side_q;
	entry_t             start_ent_q;
	logic [VW-1:0]      root_a_q, root_b_q;
	entry_t             ent_a_q, ent_b_q;
	logic [VW-1:0]      top_q;
	entry_t             child_ent_q;
	logic [RANK_W-1:0]  new_rank_q;
	logic [CW-1:0]      new_size_q;

	// staged and output result
	logic          res_merged_q, res_err_q;
	logic [VW-1:0] res_root_q;
	logic [CW-1:0] res_count_q, res_size_q;
	logic          out_valid_q, out_merged_q, out_err_q;
	logic [VW-1:0] out_root_q;
	logic [CW-1:0] out_count_q, out_size_q;

	// combinational
	entry_t        rd_eff;
	logic [CW-1:0] eff_n;
	logic          idx_bad;
	logic          walk_on;
	logic [VW-1:0] start_node;
	logic          merge_ok;
	logic          a_on_top;
	logic          slot_free;
	logic          div_start, div_done;
	logic [SCALE_W-1:0] quotient;
	logic [SUM_W-1:0]   thr_sum;
	logic [THR_W-1:0]   thr_new;
	logic [CW-1:0]      size_sum;

	// Effective vertex count and the entry seen through the epoch tag.
	always_comb begin
		if (num_vertices_q == '0) begin
			eff_n = CW'(1);
		end else if (NC_W'(num_vertices_q) > NC_W'(MAX_VERTICES)) begin
			eff_n = CW'(MAX_VERTICES);
		end else begin
			eff_n = CW'(num_vertices_q);
		end
		idx_bad = (CW'(na_q) >= eff_n) || (CW'(nb_q) >= eff_n);

		// an entry of an older epoch reads as a fresh root
		if (rdata_q.tag == epoch_q) begin
			rd_eff = rdata_q;
		end else begin
			rd_eff        = '0;
			rd_eff.tag    = epoch_q;
			rd_eff.parent = cur_q;
			rd_eff.size   = CW'(1);
			rd_eff.thr    = THR_W'(scale_k_q);
		end
		walk_on    = (rd_eff.parent != cur_q) && (steps_q < CW'(MAX_VERTICES));
		start_node = side_q ? nb_q : na_q;

		merge_ok = (root_a_q != root_b_q) && (THR_W'(w_q) <= ent_a_q.thr)
			&& (THR_W'(w_q) <= ent_b_q.thr);
		a_on_top = ent_a_q.rank > ent_b_q.rank;

		// joined set size, needed by the divider at the decide edge
		size_sum = CW'(ent_a_q.size + ent_b_q.size);

		// new threshold: weight plus the size bonus, saturated
		thr_sum = SUM_W'(w_q) + SUM_W'(quotient);
		thr_new = (thr_sum > THR_SAT) ? THR_W'(THR_SAT) : THR_W'(thr_sum);

		slot_free = !out_valid_q || results.ready;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == VW'(MAX_VERTICES - 1)) begin
					state_d = resume_q ? ST_CHECK : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (edges.valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (first_q && (epoch_q == '1)) begin
					state_d = ST_CLEAR;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = idx_bad ? ST_DONE : ST_RD;
			ST_RD:    state_d = ST_CHK;
			ST_CHK: begin
				if (walk_on) begin
					state_d = ST_RD;
				end else if (cur_q != start_node) begin
					state_d = ST_WR;
				end else begin
					state_d = side_q ? ST_DECIDE : ST_RD;
				end
			end
			ST_WR:       state_d = side_q ? ST_DECIDE : ST_RD;
			ST_DECIDE:   state_d = merge_ok ? ST_DIV : ST_DONE;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_WR_CHILD;
				end
			end
			ST_WR_CHILD: state_d = ST_WR_TOP;
			ST_WR_TOP:   state_d = ST_DONE;
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: memory write port, divider start, ready.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_idx_q;
		mem_wdata = '0;
		div_start = 1'b0;
		edges.ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				// tag zero never matches a live epoch
				mem_we = 1'b1;
			end
			ST_IDLE: edges.ready = 1'b1;
			ST_WR: begin
				// point the start node straight at its root
				mem_we           = 1'b1;
				mem_waddr        = start_node;
				mem_wdata        = start_ent_q;
				mem_wdata.tag    = epoch_q;
				mem_wdata.parent = cur_q;
			end
			ST_DECIDE: div_start = merge_ok;
			ST_WR_CHILD: begin
				mem_we           = 1'b1;
				mem_waddr        = a_on_top ? root_b_q : root_a_q;
				mem_wdata        = child_ent_q;
				mem_wdata.tag    = epoch_q;
				mem_wdata.parent = top_q;
			end
			ST_WR_TOP: begin
				mem_we           = 1'b1;
				mem_waddr        = top_q;
				mem_wdata.tag    = epoch_q;
				mem_wdata.parent = top_q;
				mem_wdata.rank   = new_rank_q;
				mem_wdata.size   = new_size_q;
				mem_wdata.thr    = thr_new;
			end
			default: ;
		endcase
	end

	// Vertex memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[cur_q];
	end

	ufgs_divider #(
		.DEN_W (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (scale_k_q),
		.divisor  (size_sum),
		.done     (div_done),
		.quotient (quotient)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			num_vertices_q <= NV_RESET;
			scale_k_q      <= SCALE_RESET;
			epoch_q        <= EPOCH_W'(1);
			sets_left_q    <= SETS_RESET;
			clr_idx_q      <= '0;
			resume_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				case (cfg_index)
					REG_NUM_VERTICES: num_vertices_q <= cfg_data[NV_W-1:0];
					REG_SCALE_K:      scale_k_q      <= cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == VW'(MAX_VERTICES - 1)) begin
						clr_idx_q <= '0;
						epoch_q   <= EPOCH_W'(1);
						resume_q  <= 1'b0;
					end
				end
				ST_START: begin
					if (first_q) begin
						sets_left_q <= eff_n;
						// wrap of the epoch forces a full sweep
						if (epoch_q == '1) begin
							resume_q <= 1'b1;
						end else begin
							epoch_q <= epoch_q + 1'b1;
						end
					end
				end
				ST_DECIDE: begin
					if (merge_ok && (sets_left_q != '0)) begin
						sets_left_q <= sets_left_q - 1'b1;
					end
				end
				default: ;
			endcase
			// hold the result until the sink takes it
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				na_q    <= edges.node_a;
				nb_q    <= edges.node_b;
				w_q     <= edges.edge_weight;
				first_q <= edges.first_edge;
			end
			ST_CHECK: begin
				cur_q   <= na_q;
				steps_q <= '0;
				side_q  <= 1'b0;
				res_merged_q <= 1'b0;
				res_root_q   <= '0;
				res_count_q  <= sets_left_q;
				res_size_q   <= '0;
				res_err_q    <= 1'b1;
			end
			ST_CHK: begin
				if (steps_q == '0) begin
					start_ent_q <= rd_eff;
				end
				if (walk_on) begin
					cur_q   <= rd_eff.parent;
					steps_q <= steps_q + 1'b1;
				end else begin
					if (side_q) begin
						root_b_q <= cur_q;
						ent_b_q  <= rd_eff;
					end else begin
						root_a_q <= cur_q;
						ent_a_q  <= rd_eff;
					end
					if (!side_q && (cur_q == start_node)) begin
						side_q  <= 1'b1;
						cur_q   <= nb_q;
						steps_q <= '0;
					end
				end
			end
			ST_WR: begin
				if (!side_q) begin
					side_q  <= 1'b1;
					cur_q   <= nb_q;
					steps_q <= '0;
				end
			end
			ST_DECIDE: begin
				new_size_q   <= size_sum;
				res_merged_q <= 1'b0;
				res_root_q   <= root_a_q;
				res_count_q  <= sets_left_q;
				res_size_q   <= ent_a_q.size;
				res_err_q    <= 1'b0;
				if (a_on_top) begin
					top_q       <= root_a_q;
					child_ent_q <= ent_b_q;
					new_rank_q  <= ent_a_q.rank;
				end else begin
					top_q       <= root_b_q;
					child_ent_q <= ent_a_q;
					new_rank_q  <= ((ent_a_q.rank == ent_b_q.rank) && (ent_b_q.rank < RANK_MAX))
						? ent_b_q.rank + 1'b1 : ent_b_q.rank;
				end
			end
			ST_WR_TOP: begin
				res_merged_q <= 1'b1;
				res_root_q   <= top_q;
				res_count_q  <= sets_left_q;
				res_size_q   <= new_size_q;
			end
			ST_DONE: begin
				if (slot_free) begin
					out_merged_q <= res_merged_q;
					out_root_q   <= res_root_q;
					out_count_q  <= res_count_q;
					out_size_q   <= res_size_q;
					out_err_q    <= res_err_q;
				end
			end
			default: ;
		endcase
	end

	assign results.valid       = out_valid_q;
	assign results.merged      = out_merged_q;
	assign results.result_root = out_root_q;
	assign results.set_count   = out_count_q;
	assign results.root_size   = out_size_q;
	assign results.index_error = out_err_q;

	`UFGS_ASSERT(a_busy_stall, (state_q != ST_IDLE) |-> !edges.ready)
	`UFGS_ASSERT(a_div_in_div, div_done |-> (state_q == ST_DIV))
	`UFGS_ASSERT_NEXT(a_accept_start, (edges.valid && edges.ready), (state_q == ST_START))
	`UFGS_ASSERT(a_merge_no_err, (results.valid && results.merged) |-> !results.index_error)
endmodule

// ===== dv/union_find_graph_segmenter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Union-find graph segmenter testbench
// Streams graphs of sorted edges, with some unsorted noise, through the segmenter under random flow
// control and checks every result against a behavioral union-find forest.
// ----------------------------------------------------------------------------
module union_find_graph_segmenter_unit_tb;
	import ufgs_pkg::*;

	localparam int NV_MAX = MAX_VERTICES_DEF;
	localparam logic [16:0] THR_SAT = 17'h1FFFF;

	typedef struct packed {
		logic [9:0]  node_a;
		logic [9:0]  node_b;
		logic [15:0] edge_weight;
		logic        first_edge;
	} edge_t;

	typedef struct packed {
		logic        merged;
		logic [9:0]  result_root;
		logic [10:0] set_count;
		logic [10:0] root_size;
		logic        index_error;
	} seg_result_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ufgs_edge_if   #(.VW(10), .WB(16)) edges ();
	ufgs_result_if #(.VW(10), .CW(11)) results ();

	union_find_graph_segmenter_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.edges    (edges),
		.results  (results)
	);

	// Shadow forest and register copies.
	logic [9:0]  link_mem [NV_MAX];
	logic [3:0]  rank_mem [NV_MAX];
	logic [10:0] size_mem [NV_MAX];
	logic [16:0] thr_mem  [NV_MAX];
	bit          live_mem [NV_MAX];
	logic [10:0] sets_left;
	logic [10:0] vertex_cfg;
	logic [15:0] k_cfg;

	edge_t       edge_queue[$];
	seg_result_t expected_results[$];
	edge_t       cur_edge;
	int          send_gap;
	int          recv_stall;
	bit          no_idle;
	bit          sender_hold;
	int          mismatches;
	int          items_made;

	// Clock: period 4.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#40000000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [10:0] eff_vertices();
		if (vertex_cfg == 11'd0) return 11'd1;
		if (vertex_cfg > 11'd1024) return 11'd1024;
		return vertex_cfg;
	endfunction

	// An entry never written since the last clear reads as a fresh root.
	function automatic logic [9:0] link_of(logic [9:0] v);
		return live_mem[v] ? link_mem[v] : v;
	endfunction

	function automatic void touch(logic [9:0] v);
		if (!live_mem[v]) begin
			live_mem[v] = 1'b1;
			link_mem[v] = v;
			rank_mem[v] = '0;
			size_mem[v] = 11'd1;
			thr_mem[v]  = {1'b0, k_cfg};
		end
	endfunction

	// Walk to the root; only the start node gets pointed at it.
	function automatic logic [9:0] find_root(logic [9:0] x);
		logic [9:0] y;
		int steps;
		y = x;
		steps = 0;
		while (link_of(y) != y && steps < NV_MAX) begin
			y = link_of(y);
			steps++;
		end
		if (y != x) begin
			touch(x);
			link_mem[x] = y;
		end
		return y;
	endfunction

	// Apply one accepted edge to the shadow forest and queue its result.
	function automatic void segment_edge(edge_t e);
		seg_result_t r;
		logic [9:0] ra, rb, child, top;
		logic [16:0] ta, tb;
		logic [17:0] t;
		logic [10:0] n;
		if (e.first_edge) begin
			foreach (live_mem[i]) live_mem[i] = 1'b0;
			sets_left = eff_vertices();
		end
		n = eff_vertices();
		r = '0;
		if (e.node_a >= n || e.node_b >= n) begin
			r.index_error = 1'b1;
			r.set_count = sets_left;
			expected_results.push_back(r);
			return;
		end
		ra = find_root(e.node_a);
		rb = find_root(e.node_b);
		r.result_root = ra;
		ta = live_mem[ra] ? thr_mem[ra] : {1'b0, k_cfg};
		tb = live_mem[rb] ? thr_mem[rb] : {1'b0, k_cfg};
		if (ra != rb && e.edge_weight <= ta && e.edge_weight <= tb) begin
			touch(ra);
			touch(rb);
			if (rank_mem[ra] > rank_mem[rb]) begin
				child = rb;
				top = ra;
			end else begin
				child = ra;
				top = rb;
				if (rank_mem[ra] == rank_mem[rb] && rank_mem[rb] < RANK_MAX)
					rank_mem[rb] = rank_mem[rb] + 1'b1;
			end
			link_mem[child] = top;
			size_mem[top] = size_mem[top] + size_mem[child];
			if (sets_left > 0) sets_left = sets_left - 1'b1;
			t = e.edge_weight + (k_cfg / size_mem[top]);
			thr_mem[top] = (t > THR_SAT) ? THR_SAT : t[16:0];
			r.result_root = top;
			r.merged = 1'b1;
		end
		r.set_count = sets_left;
		r.root_size = live_mem[r.result_root] ? size_mem[r.result_root] : 11'd1;
		expected_results.push_back(r);
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Edge driver: present the next queued edge once the current one transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (edges.valid && edges.ready) segment_edge(cur_edge);
			if (!(edges.valid && !edges.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					edges.valid <= 1'b0;
				end else if (edge_queue.size() > 0 && !sender_hold) begin
					cur_edge = edge_queue.pop_front();
					edges.node_a      <= cur_edge.node_a;
					edges.node_b      <= cur_edge.node_b;
					edges.edge_weight <= cur_edge.edge_weight;
					edges.first_edge  <= cur_edge.first_edge;
					edges.valid       <= 1'b1;
					send_gap = pick_gap();
				end else begin
					edges.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: stall at random, compare each transfer with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		seg_result_t got, want;
		if (!arst_n) begin
			results.ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (results.valid && results.ready) begin
				got.merged      = results.merged;
				got.result_root = results.result_root;
				got.set_count   = results.set_count;
				got.root_size   = results.root_size;
				got.index_error = results.index_error;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				results.ready <= 1'b0;
			end else begin
				results.ready <= 1'b1;
				recv_stall = pick_gap();
			end
		end
	end

	// Let everything in flight drain.
	task automatic wait_drained();
		while (edge_queue.size() > 0 || edges.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_NUM_VERTICES) vertex_cfg = value[10:0];
		else k_cfg = value;
	endtask

	task automatic push_edge(int a, int b, int w, bit first);
		edge_t e;
		e.node_a = 10'(a);
		e.node_b = 10'(b);
		e.edge_weight = 16'(w);
		e.first_edge = first;
		edge_queue.push_back(e);
		items_made++;
	endtask

	// One graph of sorted edges; a few endpoints stray out of range.
	task automatic push_graph(int n, int count, bit start_new);
		int w, a, b;
		w = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
		for (int i = 0; i < count; i++) begin
			a = $urandom_range(0, n - 1);
			b = $urandom_range(0, n - 1);
			if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 1023);
			if ($urandom_range(0, 19) == 0) b = $urandom_range(0, 1023);
			if ($urandom_range(0, 3) != 0) w = w + $urandom_range(0, 64);
			if (w > 65535) w = 65535;
			push_edge(a, b, w, start_new && i == 0);
		end
	endtask

	initial begin
		int n, k;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_NUM_VERTICES;
		cfg_data = '0;
		edges.valid = 1'b0;
		edges.node_a = '0;
		edges.node_b = '0;
		edges.edge_weight = '0;
		edges.first_edge = 1'b0;
		results.ready = 1'b0;
		mismatches = 0;
		items_made = 0;
		no_idle = 1'b0;
		sender_hold = 1'b0;
		vertex_cfg = NV_RESET;
		k_cfg = SCALE_RESET;
		foreach (live_mem[i]) live_mem[i] = 1'b0;
		sets_left = eff_vertices();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset configuration, full vertex range, weight extremes.
		push_edge(0, 1023, 0, 1'b1);
		push_edge(1023, 0, 16, 1'b0);
		push_edge(512, 511, 65535, 1'b0);
		push_edge(1, 1022, 100, 1'b0);
		push_edge(1022, 1023, 200, 1'b0);
		push_edge(682, 341, 300, 1'b0);
		wait_drained();

		// Small forest, k of zero: equal ranks, chains, bad endpoints.
		write_reg(REG_NUM_VERTICES, 16'd4);
		write_reg(REG_SCALE_K, 16'd0);
		push_edge(0, 1, 0, 1'b1);
		push_edge(2, 3, 0, 1'b0);
		push_edge(1, 3, 0, 1'b0);
		push_edge(0, 2, 1, 1'b0);
		push_edge(4, 0, 1, 1'b0);
		push_edge(0, 1023, 1, 1'b0);
		push_edge(3, 3, 2, 1'b0);
		wait_drained();

		// Largest k and the vertex count outside its range: zero acts as one.
		write_reg(REG_SCALE_K, 16'hFFFF);
		write_reg(REG_NUM_VERTICES, 16'd0);
		push_edge(0, 0, 65535, 1'b1);
		push_edge(1, 0, 5, 1'b0);
		wait_drained();
		write_reg(REG_NUM_VERTICES, 16'h07FF);
		push_edge(1023, 5, 65535, 1'b1);
		push_edge(7, 5, 65535, 1'b0);
		push_edge(7, 1023, 65535, 1'b0);
		wait_drained();

		// Random: graphs of sorted edges under varied settings.
		while (items_made < 2050) begin
			case ($urandom_range(0, 9))
				0: n = 1;
				1: n = 2;
				2: n = 1024;
				default: n = $urandom_range(3, 64);
			endcase
			case ($urandom_range(0, 5))
				0: k = 0;
				1: k = 65535;
				default: k = $urandom_range(0, 4095);
			endcase
			no_idle = ($urandom_range(0, 4) == 0);
			write_reg(REG_NUM_VERTICES, 16'(n));
			write_reg(REG_SCALE_K, 16'(k));
			for (int g = $urandom_range(1, 4); g > 0; g--) begin
				// Occasionally continue the old forest without a clear.
				push_graph(n, $urandom_range(4, (n > 32) ? 60 : 3 * n + 4),
					$urandom_range(0, 7) != 0);
				if ($urandom_range(0, 5) == 0) begin
					// Noise: unsorted, arbitrary fields.
					for (int j = 0; j < 4; j++)
						push_edge($urandom_range(0, 1023), $urandom_range(0, 1023),
							$urandom_range(0, 65535), $urandom_range(0, 15) == 0);
				end
			end
			// Hold the sender until the forest settles, then continue.
			if ($urandom_range(0, 3) == 0) begin
				sender_hold = 1'b1;
				while (edges.valid || expected_results.size() > 0) @(posedge clk);
				sender_hold = 1'b0;
			end
			wait_drained();
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (expected_results.size() > 0) mismatches++;
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ===== union_find_graph_segmenter_unit.f =====
+incdir+rtl
rtl/ufgs_pkg.sv
rtl/ufgs_edge_if.sv
rtl/ufgs_result_if.sv
rtl/ufgs_divider.sv
rtl/union_find_graph_segmenter_unit.sv
dv/union_find_graph_segmenter_unit_tb.sv
